/* rtl/sprite_rle_decoder_defines.svh */
// Assertion macros shared by the sprite RLE decoder checkers.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define SRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite_rle_decoder: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite_rle_decoder: next-cycle check failed");

`endif

/* rtl/srd_pkg.sv */
// Shared types and constants of the sprite RLE decoder.
// No dependencies; used by every module of the block.
package srd_pkg;

    localparam int INDEX_W      = 10;
    localparam int COLOR_W      = 8;
    localparam int COUNT_W      = 16;
    localparam int BYTE_IDX_W   = 2;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int Q_CNT_W      = 3;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_TRANS_LO = 5'b00001,
        PH_TRANS_HI = 5'b00010,
        PH_COLOR_LO = 5'b00100,
        PH_COLOR_HI = 5'b01000,
        PH_PIXEL    = 5'b10000
    } phase_t;

    // Command passed from the parser to the output stage
    typedef struct packed {
        logic               pixel;
        logic               frame_end;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha_byte;
        logic               alpha_stream;
    } cmd_t;

endpackage

/* rtl/sprite_rle_decoder.sv */
// Sprite RLE decoder: takes one stream byte per cycle, back to back, while the queue has room and results drain.
// Path: an accepted byte's command is written into the command queue, and the output register
// loads it from the queue once the output slot is free or being drained.
// Throughput: one byte per cycle; input stalls only while the four-entry queue is full.
// Asynchronous active-low reset: parser idle at the transparent count, queue and
// output empty, alpha mode on. Instantiates srd_front, srd_fifo, srd_back; uses srd_pkg.
module sprite_rle_decoder #(
    parameter int PIXELS_PER_SPRITE = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   rle_byte,
    input  logic                         last_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic                         pixel_valid,
    output logic [srd_pkg::INDEX_W-1:0]  pixel_index,
    output logic [srd_pkg::COLOR_W-1:0]  red,
    output logic [srd_pkg::COLOR_W-1:0]  green,
    output logic [srd_pkg::COLOR_W-1:0]  blue,
    output logic [srd_pkg::COLOR_W-1:0]  alpha,
    output logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         has_alpha
);

    srd_pkg::cmd_t  front_cmd;
    srd_pkg::cmd_t  head_cmd;
    logic           front_push;
    logic           q_empty;
    logic           q_pop;
    logic           in_accept;

    // Accept a byte whenever the queue has room
    assign in_accept = push && !full;
    assign cfg_ready = 1'b1;

    srd_front #(
        .PIXELS_PER_SPRITE (PIXELS_PER_SPRITE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_alpha (has_alpha),
        .in_accept (in_accept),
        .rle_byte  (rle_byte),
        .last_byte (last_byte),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    srd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (head_cmd),
        .full    (full),
        .empty   (q_empty)
    );

    srd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (q_empty),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .pixel_valid (pixel_valid),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .frame_end   (frame_end)
    );

endmodule

/* rtl/srd_front.sv */
// Stream parser of the sprite RLE decoder: takes bytes, tracks runs, issues commands.
// Depends on srd_pkg.
module srd_front #(
    parameter int PIXELS_PER_SPRITE = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr,
    input  logic          cfg_alpha,
    input  logic          in_accept,
    input  logic [7:0]    rle_byte,
    input  logic          last_byte,
    output logic          cmd_push,
    output srd_pkg::cmd_t cmd
);

    localparam int POS_W = $clog2(PIXELS_PER_SPRITE + 1);
    localparam int SUM_W = ((POS_W > srd_pkg::COUNT_W) ? POS_W : srd_pkg::COUNT_W) + 1;

    srd_pkg::phase_t                    phase_reg, phase_next;
    logic [7:0]                         count_low_reg, count_low_next;
    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic [srd_pkg::COUNT_W-1:0]        rem_reg, rem_next;
    logic [srd_pkg::BYTE_IDX_W-1:0]     bip_reg, bip_next;
    logic [srd_pkg::COLOR_W-1:0]        blue_reg, blue_next;
    logic [srd_pkg::COLOR_W-1:0]        green_reg, green_next;
    logic [srd_pkg::COLOR_W-1:0]        red_reg, red_next;
    logic                               done_reg, done_next;
    logic                               has_alpha_reg;

    logic                               emit;
    logic                               complete;
    logic [SUM_W-1:0]                   skip_sum;
    logic [POS_W-1:0]                   pos_inc;
    logic [srd_pkg::COUNT_W-1:0]        rem_dec;

    // Hold the alpha-mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            has_alpha_reg <= cfg_alpha;
        end
    end

    // Shared arithmetic of the run and pixel phases
    assign skip_sum = SUM_W'(pos_reg) + SUM_W'({rle_byte, count_low_reg});
    assign pos_inc  = pos_reg + POS_W'(1);
    assign rem_dec  = rem_reg - srd_pkg::COUNT_W'(1);
    assign complete = has_alpha_reg ? (bip_reg == 2'd3) : bip_reg[1];

    // Advance the parser on each accepted byte
    always_comb
    begin
        phase_next     = phase_reg;
        count_low_next = count_low_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        bip_next       = bip_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        done_next      = done_reg;
        emit           = 1'b0;

        if (in_accept && !done_reg)
        begin
            unique case (phase_reg)
                srd_pkg::PH_TRANS_LO:
                begin
                    count_low_next = rle_byte;
                    phase_next     = srd_pkg::PH_TRANS_HI;
                end
                srd_pkg::PH_COLOR_LO:
                begin
                    count_low_next = rle_byte;
                    phase_next     = srd_pkg::PH_COLOR_HI;
                end
                srd_pkg::PH_TRANS_HI:
                begin
                    if (skip_sum >= SUM_W'(PIXELS_PER_SPRITE))
                    begin
                        pos_next  = POS_W'(PIXELS_PER_SPRITE);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = POS_W'(skip_sum);
                    end
                    phase_next = srd_pkg::PH_COLOR_LO;
                end
                srd_pkg::PH_COLOR_HI:
                begin
                    rem_next   = {rle_byte, count_low_reg};
                    bip_next   = '0;
                    phase_next = ({rle_byte, count_low_reg} == '0) ?
                                 srd_pkg::PH_TRANS_LO : srd_pkg::PH_PIXEL;
                end
                srd_pkg::PH_PIXEL:
                begin
                    if (!complete)
                    begin
                        case (bip_reg)
                            2'd0:    blue_next  = rle_byte;
                            2'd1:    green_next = rle_byte;
                            default: red_next   = rle_byte;
                        endcase
                        bip_next = bip_reg + 2'd1;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        bip_next = '0;
                        pos_next = pos_inc;
                        rem_next = rem_dec;
                        if (pos_inc >= POS_W'(PIXELS_PER_SPRITE))
                        begin
                            done_next = 1'b1;
                        end
                        else if (rem_dec == '0)
                        begin
                            phase_next = srd_pkg::PH_TRANS_LO;
                        end
                    end
                end
                default:
                begin
                    phase_next = srd_pkg::PH_TRANS_LO;
                end
            endcase
        end

        // Drop any partial count or pixel at the end of the stream
        if (in_accept && last_byte)
        begin
            phase_next = srd_pkg::PH_TRANS_LO;
            pos_next   = '0;
            rem_next   = '0;
            bip_next   = '0;
            done_next  = 1'b0;
        end
    end

    // Build the command for the output stage
    always_comb
    begin
        cmd_push         = in_accept && (emit || last_byte);
        cmd.pixel        = emit;
        cmd.frame_end    = last_byte;
        cmd.index        = srd_pkg::INDEX_W'(pos_reg);
        cmd.blue         = blue_reg;
        cmd.green        = green_reg;
        cmd.red          = (!has_alpha_reg && (bip_reg == 2'd2)) ? rle_byte : red_reg;
        cmd.alpha_byte   = rle_byte;
        cmd.alpha_stream = has_alpha_reg;
    end

    // Parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= srd_pkg::PH_TRANS_LO;
            pos_reg   <= '0;
            rem_reg   <= '0;
            bip_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            bip_reg   <= bip_next;
            done_reg  <= done_next;
        end
    end

    // Count and pixel byte holds
    always_ff @(posedge clk)
    begin
        count_low_reg <= count_low_next;
        blue_reg      <= blue_next;
        green_reg     <= green_next;
        red_reg       <= red_next;
    end

endmodule

/* rtl/srd_fifo.sv */
// Short command queue between the parser and the output stage of the decoder.
// Depends on srd_pkg.
module srd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  srd_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output srd_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    srd_pkg::cmd_t                  mem_reg [srd_pkg::Q_DEPTH];
    logic [srd_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [srd_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [srd_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_wr;
    logic                           do_rd;

    assign full    = (cnt_reg == srd_pkg::Q_CNT_W'(srd_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + srd_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + srd_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + srd_pkg::Q_CNT_W'(1);
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - srd_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/srd_back.sv */
// Output stage of the decoder: formats commands into result transactions.
// Depends on srd_pkg.
module srd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_empty,
    input  srd_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic                         pixel_valid,
    output logic [srd_pkg::INDEX_W-1:0]  pixel_index,
    output logic [srd_pkg::COLOR_W-1:0]  red,
    output logic [srd_pkg::COLOR_W-1:0]  green,
    output logic [srd_pkg::COLOR_W-1:0]  blue,
    output logic [srd_pkg::COLOR_W-1:0]  alpha,
    output logic                         frame_end
);

    logic                         out_valid_reg;
    logic                         pixel_valid_reg;
    logic [srd_pkg::INDEX_W-1:0]  index_reg;
    logic [srd_pkg::COLOR_W-1:0]  red_reg;
    logic [srd_pkg::COLOR_W-1:0]  green_reg;
    logic [srd_pkg::COLOR_W-1:0]  blue_reg;
    logic [srd_pkg::COLOR_W-1:0]  alpha_reg;
    logic                         frame_end_reg;
    logic [srd_pkg::COLOR_W-1:0]  alpha_sel;
    logic                         load;

    // Take the next command when the output slot is free or being drained
    assign load    = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_pop = load;

    assign alpha_sel = cmd.alpha_stream ? cmd.alpha_byte : srd_pkg::ALPHA_OPAQUE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Format the result; a frame-end without a pixel carries zero fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_valid_reg <= cmd.pixel;
            frame_end_reg   <= cmd.frame_end;
            index_reg       <= cmd.pixel ? cmd.index : '0;
            red_reg         <= cmd.pixel ? cmd.red   : '0;
            green_reg       <= cmd.pixel ? cmd.green : '0;
            blue_reg        <= cmd.pixel ? cmd.blue  : '0;
            alpha_reg       <= cmd.pixel ? alpha_sel : '0;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_index = index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign alpha       = alpha_reg;
    assign frame_end   = frame_end_reg;

endmodule

/* rtl/srd_checker.sv */
// Port-level checks of the sprite RLE decoder, bound to the top level.
// Depends on srd_pkg and sprite_rle_decoder_defines.svh.
`include "sprite_rle_decoder_defines.svh"

module srd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         push,
    input logic                         full,
    input logic [7:0]                   rle_byte,
    input logic                         last_byte,
    input logic                         empty,
    input logic                         pop,
    input logic                         pixel_valid,
    input logic [srd_pkg::INDEX_W-1:0]  pixel_index,
    input logic [srd_pkg::COLOR_W-1:0]  red,
    input logic [srd_pkg::COLOR_W-1:0]  green,
    input logic [srd_pkg::COLOR_W-1:0]  blue,
    input logic [srd_pkg::COLOR_W-1:0]  alpha,
    input logic                         frame_end,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         has_alpha
);

    // A waiting result that is not taken holds
    `SRD_ASSERT_NEXT(a_result_hold, !empty && !pop,
        !empty && $stable({pixel_valid, pixel_index, red, green, blue, alpha, frame_end}))

    // A result without a pixel only marks the end of a frame
    `SRD_ASSERT_SAME(a_nopixel_is_end, !empty && !pixel_valid, frame_end)

    // A result without a pixel carries zero fields
    `SRD_ASSERT_SAME(a_nopixel_zero, !empty && !pixel_valid,
        pixel_index == '0 && red == '0 && green == '0 && blue == '0 && alpha == '0)

endmodule

bind sprite_rle_decoder srd_checker u_srd_checker (.*);

/* dv/tb_top.sv */
// Testbench for sprite_rle_decoder: directed stream table, then random sprite streams.
// Every accepted byte runs through a behavioral decoder whose results are checked in order.
// Depends on srd_pkg and the sprite_rle_decoder RTL.
module tb_top;

    localparam int PIXELS    = 1024;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 8;
    localparam int SEG_ITEMS = 80;

    // Kind of a directed table row and how its result is checked
    localparam logic ROW_DATA  = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        logic                        pixel_valid;
        logic [srd_pkg::INDEX_W-1:0] index;
        logic [srd_pkg::COLOR_W-1:0] red;
        logic [srd_pkg::COLOR_W-1:0] green;
        logic [srd_pkg::COLOR_W-1:0] blue;
        logic [srd_pkg::COLOR_W-1:0] alpha;
        logic                        frame_end;
    } pix_write_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       fin;
        logic       chk;
        pix_write_t want;
    } dir_row_t;

    localparam pix_write_t NO_WANT    = '0;
    localparam pix_write_t FRAME_ONLY = {1'b0, 10'd0, 32'd0, 1'b1};

    localparam dir_row_t DIR_TABLE [26] = '{
        // lone last byte right after reset
        {ROW_DATA, 8'h00, 1'b1, CHK_TYPED, FRAME_ONLY},
        // no skip, one colored pixel finished by the last byte
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h01, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'hFF, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h80, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h01, 1'b1, CHK_TYPED, {1'b1, 10'd0, 8'h80, 8'hFF, 8'h00, 8'h01, 1'b1}},
        // maximum skip saturates, decoding stops
        {ROW_DATA, 8'hFF, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'hFF, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h34, 1'b1, CHK_TYPED, FRAME_ONLY},
        // skip 5, empty colored run, skip 0, one pixel
        {ROW_DATA, 8'h05, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h01, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h11, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h22, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h33, 1'b0, CHK_PRED,  NO_WANT},
        // drop alpha mode with three bytes of the pixel held
        {ROW_CFG,  8'h00, 1'b0, CHK_PRED,  NO_WANT},
        {ROW_DATA, 8'h44, 1'b0, CHK_PRED,  NO_WANT},
        // partial count discarded by the last byte
        {ROW_DATA, 8'h66, 1'b1, CHK_TYPED, FRAME_ONLY}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic [7:0]                   rle_byte = 8'h00;
    logic                         last_byte = 1'b0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic                         pixel_valid;
    logic [srd_pkg::INDEX_W-1:0]  pixel_index;
    logic [srd_pkg::COLOR_W-1:0]  red;
    logic [srd_pkg::COLOR_W-1:0]  green;
    logic [srd_pkg::COLOR_W-1:0]  blue;
    logic [srd_pkg::COLOR_W-1:0]  alpha;
    logic                         frame_end;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         has_alpha = 1'b1;

    // Decoder state mirrored by the testbench
    logic                         alpha_mode;
    srd_pkg::phase_t              dec_phase;
    logic [7:0]                   dec_low;
    logic [10:0]                  dec_pos;
    logic [srd_pkg::COUNT_W-1:0]  dec_left;
    logic [1:0]                   dec_bip;
    logic [7:0]                   dec_blue;
    logic [7:0]                   dec_green;
    logic [7:0]                   dec_red;
    logic                         dec_done;

    pix_write_t          pending_writes [$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  items_sent = 0;
    int                  mismatches = 0;
    int                  cycles = 0;

    sprite_rle_decoder #(
        .PIXELS_PER_SPRITE(PIXELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rle_byte(rle_byte),
        .last_byte(last_byte),
        .empty(empty),
        .pop(pop),
        .pixel_valid(pixel_valid),
        .pixel_index(pixel_index),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .frame_end(frame_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .has_alpha(has_alpha)
    );

    always #5 clk = ~clk;

    // Bound the run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic clear_decoder();
        dec_phase = srd_pkg::PH_TRANS_LO;
        dec_low   = '0;
        dec_pos   = '0;
        dec_left  = '0;
        dec_bip   = '0;
        dec_blue  = '0;
        dec_green = '0;
        dec_red   = '0;
        dec_done  = 1'b0;
    endtask

    // Advance the decoder by one stream byte; report the write it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic fin,
                               output logic emitted, output pix_write_t res);
        int   next_pos;
        logic complete;
        res = '0;
        emitted = 1'b0;
        if (!dec_done)
        begin
            case (dec_phase)
                srd_pkg::PH_TRANS_LO, srd_pkg::PH_COLOR_LO:
                begin
                    dec_low   = b;
                    dec_phase = (dec_phase == srd_pkg::PH_TRANS_LO) ?
                                srd_pkg::PH_TRANS_HI : srd_pkg::PH_COLOR_HI;
                end
                srd_pkg::PH_TRANS_HI:
                begin
                    next_pos = int'(dec_pos) + int'({b, dec_low});
                    if (next_pos >= PIXELS)
                    begin
                        next_pos = PIXELS;
                        dec_done = 1'b1;
                    end
                    dec_pos   = next_pos[10:0];
                    dec_phase = srd_pkg::PH_COLOR_LO;
                end
                srd_pkg::PH_COLOR_HI:
                begin
                    dec_left  = {b, dec_low};
                    dec_bip   = '0;
                    dec_phase = (dec_left == '0) ? srd_pkg::PH_TRANS_LO : srd_pkg::PH_PIXEL;
                end
                default:
                begin
                    complete = alpha_mode ? (dec_bip == 2'd3) : (dec_bip >= 2'd2);
                    if (!complete)
                    begin
                        if (dec_bip == 2'd0)
                            dec_blue = b;
                        else if (dec_bip == 2'd1)
                            dec_green = b;
                        else
                            dec_red = b;
                        dec_bip = dec_bip + 2'd1;
                    end
                    else
                    begin
                        emitted         = 1'b1;
                        res.pixel_valid = 1'b1;
                        res.index       = dec_pos[srd_pkg::INDEX_W-1:0];
                        res.blue        = dec_blue;
                        res.green       = dec_green;
                        if (alpha_mode)
                        begin
                            res.red   = dec_red;
                            res.alpha = b;
                        end
                        else
                        begin
                            // three bytes per pixel: this byte is red unless red is already held
                            res.red   = (dec_bip == 2'd2) ? b : dec_red;
                            res.alpha = srd_pkg::ALPHA_OPAQUE;
                        end
                        dec_bip  = '0;
                        dec_pos  = dec_pos + 11'd1;
                        dec_left = dec_left - srd_pkg::COUNT_W'(1);
                        if (dec_pos >= 11'(PIXELS))
                            dec_done = 1'b1;
                        else if (dec_left == '0)
                            dec_phase = srd_pkg::PH_TRANS_LO;
                    end
                end
            endcase
        end
        res.frame_end = fin;
        if (fin)
            clear_decoder();
    endtask

    // Offer one byte, hold it until accepted, then record the expected write, if any
    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input logic typed, input pix_write_t want);
        logic       emitted;
        pix_write_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        rle_byte  <= b;
        last_byte <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        decode_byte(b, fin, emitted, res);
        if (emitted || fin)
            pending_writes.push_back(typed ? want : res);
    endtask

    // Write the alpha mode register once the block has drained
    task automatic write_alpha_mode(input logic v);
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        has_alpha <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        alpha_mode = v;
    endtask

    // Build one sprite stream, mostly well formed, and send it
    task automatic send_random_sprite();
        logic [7:0] stream [$];
        logic       ends;
        int         skip;
        int         colors;
        int         npix;
        int         bpp;
        int         roll;
        int         at;
        int         cut;
        at   = 0;
        ends = 1'b1;
        if ($urandom_range(0, 99) < 8)
        begin
            // raw noise
            repeat ($urandom_range(1, 12)) stream.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    skip = $urandom_range(0, 6);
                else if (roll < 75)
                    skip = $urandom_range(0, PIXELS - 1);
                else if (roll < 90)
                begin
                    // land the next pixels on the final positions
                    skip = PIXELS - 1 - at - $urandom_range(0, 2);
                    if (skip < 0)
                        skip = 0;
                end
                else
                    skip = $urandom_range(PIXELS, 65535);
                if ($urandom_range(0, 99) < 85)
                    colors = $urandom_range(0, 5);
                else
                    colors = $urandom_range(7, 65535);
                npix = (colors > 6) ? $urandom_range(0, 6) : colors;
                bpp  = alpha_mode ? 4 : 3;
                if ($urandom_range(0, 99) < 10)
                    bpp = 7 - bpp;
                stream.push_back(skip[7:0]);
                stream.push_back(skip[15:8]);
                stream.push_back(colors[7:0]);
                stream.push_back(colors[15:8]);
                repeat (npix * bpp) stream.push_back(8'($urandom_range(0, 255)));
                at = at + skip + npix;
            end
        end
        // choose how the stream ends
        roll = $urandom_range(0, 99);
        if (roll >= 40 && roll < 80)
            stream.push_back(8'($urandom_range(0, 255)));
        else if (roll >= 80 && roll < 90)
        begin
            cut = $urandom_range(1, stream.size());
            while (stream.size() > cut)
                void'(stream.pop_back());
        end
        else if (roll >= 90)
            ends = 1'b0;
        foreach (stream[i])
            send_byte(stream[i], ends && (i == stream.size() - 1), 1'b0, NO_WANT);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Take results and check them against the oldest expected write
    always @(posedge clk)
    begin
        pix_write_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("result with no expected write: pixel_valid %0b index 0x%0h",
                       pixel_valid, pixel_index);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                compare_field("pixel_valid", want.pixel_valid, pixel_valid);
                compare_field("pixel_index", want.index, pixel_index);
                compare_field("red", want.red, red);
                compare_field("green", want.green, green);
                compare_field("blue", want.blue, blue);
                compare_field("alpha", want.alpha, alpha);
                compare_field("frame_end", want.frame_end, frame_end);
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        int target;
        alpha_mode = 1'b1;
        clear_decoder();
        send_idle_pct = 9;
        recv_idle_pct = 73;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (DIR_TABLE[i])
        begin
            if (DIR_TABLE[i].kind == ROW_CFG)
                write_alpha_mode(DIR_TABLE[i].data[0]);
            else
                send_byte(DIR_TABLE[i].data, DIR_TABLE[i].fin,
                          DIR_TABLE[i].chk == CHK_TYPED, DIR_TABLE[i].want);
        end

        // Random segments: two per idling mode, alpha mode set before each
        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg == 0)
                write_alpha_mode(1'b1);
            else if (seg == 1)
                write_alpha_mode(1'b0);
            else
                write_alpha_mode(1'($urandom_range(0, 1)));
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = items_sent + SEG_ITEMS;
            while (items_sent < target)
                send_random_sprite();
        end

        // Drain and finish
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
